/* src/sfdtd_pkg.sv */
// Shared constants, microcode types and control store of the 1-D FDTD sweep unit.
package sfdtd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_FRAC        = 14;
  localparam int POT_W            = 16;
  localparam int PHASE_W          = 18;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0]  CFG_LAPLACE = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_GAIN    = 2'd1;
  localparam logic [CFG_DATA_W-1:0] LAPLACE_RST = 16'd1638;
  localparam logic [CFG_DATA_W-1:0] GAIN_RST    = 16'd0;

  // points held: nothing, the sweep's first point, an inner point
  localparam logic [1:0] SEEN_EMPTY = 2'd0;
  localparam logic [1:0] SEEN_FIRST = 2'd1;
  localparam logic [1:0] SEEN_INNER = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_PH_MUL, ST_PH_HI, ST_RA_LAPI, ST_ACC_NR, ST_WB_NR,
    ST_RA_LAPR, ST_PH_NR, ST_ACC_NI, ST_WB_NI, ST_RES_NEW, ST_RES_HELD,
    ST_SQ_RE, ST_SQ_IM, ST_SQ_SUM, ST_EMIT, ST_CHK_LAST, ST_HOLD_INNER,
    ST_RES_IN, ST_FIRST, ST_HOLD_FIRST
  } step_e;

  typedef enum logic [2:0] {A_GAIN, A_PHP, A_PHQ, A_RA, A_RR, A_RI} a_sel_e;
  typedef enum logic [2:0] {B_POT, B_HI, B_LAPI, B_LAPR, B_NR, B_RR, B_RI} b_sel_e;
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_e;
  typedef enum logic [1:0] {WB_NONE, WB_NR, WB_NI} wb_sel_e;
  typedef enum logic [1:0] {RES_NONE, RES_HELD, RES_NEW, RES_IN} res_sel_e;
  typedef enum logic [1:0] {SO_KEEP, SO_EMPTY, SO_FIRST, SO_INNER} seen_op_e;
  typedef enum logic [1:0] {WT_NONE, WT_IN, WT_OUT} wait_e;
  typedef enum logic [2:0] {
    JC_NEXT, JC_ALWAYS, JC_SEEN0, JC_SEEN1, JC_LAST, JC_RES_LAST
  } jcond_e;

  typedef struct packed {
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    acc_op_e  acc_op;
    wb_sel_e  wb;
    res_sel_e res;
    seen_op_e seen_op;
    wait_e    wait_sel;
    logic     phase_ld;
    logic     hold;
    jcond_e   cond;
    step_e    target;
  } uword_t;

  // control store: one word per step
  function automatic uword_t ucode(input step_e pc);
    uword_t w;
    w = '0;
    unique case (pc)
      ST_IDLE:       w.wait_sel = WT_IN;
      ST_DISP:       begin w.cond = JC_SEEN0; w.target = ST_FIRST; end
      ST_PH_MUL:     begin
        w.a_sel = A_GAIN; w.b_sel = B_POT;
        w.cond = JC_SEEN1; w.target = ST_RES_HELD;
      end
      ST_PH_HI:      begin w.a_sel = A_PHP; w.b_sel = B_HI; w.phase_ld = 1'b1; end
      ST_RA_LAPI:    begin w.a_sel = A_RA; w.b_sel = B_LAPI; w.acc_op = ACC_LOAD; end
      ST_ACC_NR:     w.acc_op = ACC_SUB;
      ST_WB_NR:      w.wb = WB_NR;
      ST_RA_LAPR:    begin w.a_sel = A_RA; w.b_sel = B_LAPR; end
      ST_PH_NR:      begin w.a_sel = A_PHQ; w.b_sel = B_NR; w.acc_op = ACC_LOAD; end
      ST_ACC_NI:     w.acc_op = ACC_SUB;
      ST_WB_NI:      w.wb = WB_NI;
      ST_RES_NEW:    begin w.res = RES_NEW; w.cond = JC_ALWAYS; w.target = ST_SQ_RE; end
      ST_RES_HELD:   w.res = RES_HELD;
      ST_SQ_RE:      begin w.a_sel = A_RR; w.b_sel = B_RR; end
      ST_SQ_IM:      begin w.a_sel = A_RI; w.b_sel = B_RI; w.acc_op = ACC_LOAD; end
      ST_SQ_SUM:     w.acc_op = ACC_ADD;
      ST_EMIT:       begin
        w.wait_sel = WT_OUT; w.cond = JC_RES_LAST; w.target = ST_IDLE;
      end
      ST_CHK_LAST:   begin w.cond = JC_LAST; w.target = ST_RES_IN; end
      ST_HOLD_INNER: begin
        w.hold = 1'b1; w.seen_op = SO_INNER; w.cond = JC_ALWAYS; w.target = ST_IDLE;
      end
      ST_RES_IN:     begin
        w.res = RES_IN; w.seen_op = SO_EMPTY; w.cond = JC_ALWAYS; w.target = ST_SQ_RE;
      end
      ST_FIRST:      begin w.cond = JC_LAST; w.target = ST_RES_IN; end
      ST_HOLD_FIRST: begin
        w.hold = 1'b1; w.seen_op = SO_FIRST; w.cond = JC_ALWAYS; w.target = ST_IDLE;
      end
      default:       w.target = ST_IDLE;
    endcase
    return w;
  endfunction

endpackage

/* src/sfdtd_if.sv */
// Request channels of the FDTD sweep unit: grid points in, updated points out.
interface sfdtd_in_if #(
  parameter int SampleWidth = sfdtd_pkg::SAMPLE_WIDTH_DEF
);
  import sfdtd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] in_real;
  logic signed [SampleWidth-1:0] in_imag;
  logic [POT_W-1:0]              in_potential;
  logic                          first_point;
  logic                          last_point;

  modport source (output valid, in_real, in_imag, in_potential, first_point, last_point,
                  input ready);
  modport sink   (input valid, in_real, in_imag, in_potential, first_point, last_point,
                  output ready);
endinterface

interface sfdtd_out_if #(
  parameter int SampleWidth = sfdtd_pkg::SAMPLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] out_real;
  logic signed [SampleWidth-1:0] out_imag;
  logic [SampleWidth+1:0]        out_probability;
  logic                          out_last;

  modport source (output valid, out_real, out_imag, out_probability, out_last,
                  input ready);
  modport sink   (input valid, out_real, out_imag, out_probability, out_last,
                  output ready);
endinterface

/* src/schrodinger_fdtd_sweep_1d_unit.sv */
// One in-place sweep of a 1-D Schrodinger FDTD step, driven by a microcoded sequencer.
//
// Grid points enter one at a time; each result leaves one point later, once the
// right neighbour has arrived, and the last point of a longer sweep releases two results.
// End points pass through unchanged. All products go through a single registered
// signed multiplier stepped by a 22-word control store, so the rate is set by that
// multiplier and the in-place dependence on the freshly updated left neighbour:
// a new point is taken only in the idle step, after an inner point has run its seven
// products, accumulate, round and saturate, then the probability square sum, and
// stalls on the result side hold the sequencer. Results sit in an output register,
// so a taken result frees the sequencer at once. Configuration writes apply at the
// edge they are issued.
module schrodinger_fdtd_sweep_1d_unit #(
  parameter int SAMPLE_WIDTH = sfdtd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfdtd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfdtd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  sfdtd_in_if.sink                          in_req,
  sfdtd_out_if.source                       out_req
);
  import sfdtd_pkg::*;

  localparam int W    = SAMPLE_WIDTH;
  localparam int AW   = (W > PHASE_W + 1) ? W : PHASE_W + 1;
  localparam int BW   = (W + 3 > POT_W + 1) ? W + 3 : POT_W + 1;
  localparam int PW   = AW + BW;
  localparam int ACCW = PW + 1;
  localparam logic signed [ACCW-1:0] RndBias = ACCW'(1) << (COEF_FRAC - 1);
  localparam logic signed [W-1:0]    SatMax  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]    SatMin  = {1'b1, {(W-1){1'b0}}};

  // configuration
  logic [CFG_DATA_W-1:0] ra_q, gain_q;

  // sweep state
  logic signed [W-1:0] lnr_q, lni_q, hr_q, hi_q;
  logic [POT_W-1:0]    hp_q;
  logic [1:0]          seen_q;

  // datapath
  logic signed [W-1:0]    xr_q, xi_q, nr_q, ni_q, rr_q, ri_q;
  logic [POT_W-1:0]       xp_q;
  logic                   xlast_q, rl_q;
  logic [PHASE_W-1:0]     phase_q;
  logic signed [AW-1:0]   a_op;
  logic signed [BW-1:0]   b_op, lap_i, lap_r;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACCW-1:0] acc_q, acc_d, acc_rnd;
  logic signed [ACCW:0]   wb_sum;
  logic signed [W-1:0]    wb_base, wb_val;

  // output register
  logic                   out_valid_q, out_last_q;
  logic signed [W-1:0]    out_real_q, out_imag_q;
  logic [W+1:0]           out_prob_q;

  // sequencer
  step_e  pc_q, pc_d;
  uword_t uw;
  logic   in_fire, out_free, adv, jump, emit_go;

  assign uw       = ucode(pc_q);
  assign in_fire  = in_req.valid && (pc_q == ST_IDLE);
  assign out_free = !out_valid_q || out_req.ready;
  assign emit_go  = adv && (uw.wait_sel == WT_OUT);

  always_comb begin
    case (uw.wait_sel)
      WT_IN:   adv = in_fire;
      WT_OUT:  adv = out_free;
      default: adv = 1'b1;
    endcase
  end

  always_comb begin
    case (uw.cond)
      JC_ALWAYS:   jump = 1'b1;
      JC_SEEN0:    jump = (seen_q == SEEN_EMPTY);
      JC_SEEN1:    jump = (seen_q == SEEN_FIRST);
      JC_LAST:     jump = xlast_q;
      JC_RES_LAST: jump = rl_q;
      default:     jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (!adv) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = step_e'(pc_q + 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // operand selection
  assign lap_i = BW'(lni_q) - (BW'(hi_q) <<< 1) + BW'(xi_q);
  assign lap_r = BW'(lnr_q) - (BW'(nr_q) <<< 1) + BW'(xr_q);

  always_comb begin
    case (uw.a_sel)
      A_GAIN:  a_op = AW'(gain_q);
      A_PHP:   a_op = AW'(prod_q[COEF_FRAC +: PHASE_W]);
      A_PHQ:   a_op = AW'(phase_q);
      A_RA:    a_op = AW'(ra_q);
      A_RR:    a_op = AW'(rr_q);
      A_RI:    a_op = AW'(ri_q);
      default: a_op = AW'(ra_q);
    endcase
  end

  always_comb begin
    case (uw.b_sel)
      B_POT:   b_op = BW'(hp_q);
      B_HI:    b_op = BW'(hi_q);
      B_LAPI:  b_op = lap_i;
      B_LAPR:  b_op = lap_r;
      B_NR:    b_op = BW'(nr_q);
      B_RR:    b_op = BW'(rr_q);
      B_RI:    b_op = BW'(ri_q);
      default: b_op = BW'(hi_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
  end

  // accumulator
  always_comb begin
    case (uw.acc_op)
      ACC_LOAD: acc_d = ACCW'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACCW'(prod_q);
      ACC_SUB:  acc_d = acc_q - ACCW'(prod_q);
      default:  acc_d = acc_q;
    endcase
  end

  // round to nearest (ties up), add to the old part, clamp
  always_comb begin
    wb_base = (uw.wb == WB_NI) ? hi_q : hr_q;
    acc_rnd = (acc_q + RndBias) >>> COEF_FRAC;
    wb_sum  = (ACCW+1)'(wb_base) + (ACCW+1)'(acc_rnd);
    if ((&wb_sum[ACCW:W-1]) || !(|wb_sum[ACCW:W-1])) begin
      wb_val = wb_sum[W-1:0];
    end else if (wb_sum[ACCW]) begin
      wb_val = SatMin;
    end else begin
      wb_val = SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc_q <= acc_d;
      if (uw.phase_ld) phase_q <= prod_q[COEF_FRAC +: PHASE_W];
      if (uw.wb == WB_NR) nr_q <= wb_val;
      if (uw.wb == WB_NI) ni_q <= wb_val;
      case (uw.res)
        RES_HELD: begin rr_q <= hr_q; ri_q <= hi_q; rl_q <= 1'b0; end
        RES_NEW:  begin rr_q <= nr_q; ri_q <= ni_q; rl_q <= 1'b0; end
        RES_IN:   begin rr_q <= xr_q; ri_q <= xi_q; rl_q <= 1'b1; end
        default:  ;
      endcase
    end
    if (in_fire) begin
      xr_q    <= in_req.in_real;
      xi_q    <= in_req.in_imag;
      xp_q    <= in_req.in_potential;
      xlast_q <= in_req.last_point;
    end
  end

  // sweep state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q   <= LAPLACE_RST;
      gain_q <= GAIN_RST;
      lnr_q  <= '0;
      lni_q  <= '0;
      hr_q   <= '0;
      hi_q   <= '0;
      hp_q   <= '0;
      seen_q <= SEEN_EMPTY;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_LAPLACE)) ra_q <= cfg_wdata_i;
      if (cfg_we_i && (cfg_idx_i == CFG_GAIN)) gain_q <= cfg_wdata_i;
      if (adv && (uw.wb == WB_NI)) begin
        lnr_q <= nr_q;
        lni_q <= wb_val;
      end
      // the first point of a sweep becomes the left neighbour unchanged
      if (adv && (uw.res == RES_HELD)) begin
        lnr_q <= hr_q;
        lni_q <= hi_q;
      end
      if (adv && uw.hold) begin
        hr_q <= xr_q;
        hi_q <= xi_q;
        hp_q <= xp_q;
      end
      // a start mark drops whatever point is held
      if (in_fire && in_req.first_point) begin
        seen_q <= SEEN_EMPTY;
      end else if (adv) begin
        case (uw.seen_op)
          SO_EMPTY: seen_q <= SEEN_EMPTY;
          SO_FIRST: seen_q <= SEEN_FIRST;
          SO_INNER: seen_q <= SEEN_INNER;
          default:  ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_real_q <= rr_q;
      out_imag_q <= ri_q;
      out_prob_q <= acc_q[W-2 +: W+2];
      out_last_q <= rl_q;
    end
  end

  assign in_req.ready            = (pc_q == ST_IDLE);
  assign out_req.valid           = out_valid_q;
  assign out_req.out_real        = out_real_q;
  assign out_req.out_imag        = out_imag_q;
  assign out_req.out_probability = out_prob_q;
  assign out_req.out_last        = out_last_q;

  a_seen_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("held-point count out of range");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pc_q == ST_DISP)
    else $error("accepted request did not reach dispatch");

  a_update_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_WB_NR) |-> seen_q == SEEN_INNER)
    else $error("update without an inner point held");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == ST_EMIT))
    else $error("result loaded outside the emit step");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && rl_q) |=> pc_q == ST_IDLE)
    else $error("sequencer did not finish after the last result");

endmodule

/* test/schrodinger_fdtd_sweep_1d_unit_test.sv */
// Self-checking testbench for the 1-D FDTD sweep unit: directed sweeps, then random sweeps.
`timescale 1ns / 100ps

module schrodinger_fdtd_sweep_1d_unit_test;
  import sfdtd_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int POINTS_PER_SETTING = 200;
  localparam int NUM_SETTINGS = 6;
  localparam int MAX_REPORTS = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic [POT_W-1:0]     pot;
    logic                 first;
    logic                 last;
  } point_t;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic [SW+1:0]        prob;
    logic                 last;
  } result_t;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic [POT_W-1:0]     pot;
    logic                 first;
    logic                 last;
    logic                 typed;
    logic signed [SW-1:0] want_re;
    logic signed [SW-1:0] want_im;
    logic [SW+1:0]        want_prob;
  } table_row_t;

  // typed rows give the pass-through point that closes the sweep (out_last set)
  table_row_t directed_rows [19] = '{
    '{32767, -32768, 0, 1, 1, 1, 32767, -32768, 131068},
    '{0, 0, 65535, 1, 1, 1, 0, 0, 0},
    '{-32768, -32768, 0, 1, 1, 1, -32768, -32768, 131072},
    '{16384, 0, 0, 0, 1, 1, 16384, 0, 16384},
    '{100, -200, 7, 1, 0, 0, 0, 0, 0},
    '{-16384, 16384, 0, 0, 1, 1, -16384, 16384, 32768},
    '{1234, 4321, 0, 1, 0, 0, 0, 0, 0},
    '{555, -555, 0, 1, 0, 0, 0, 0, 0},
    '{32767, 32767, 65535, 0, 0, 0, 0, 0, 0},
    '{-32768, -32768, 0, 0, 0, 0, 0, 0, 0},
    '{32767, -32768, 65535, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-1, 1, 1, 0, 0, 0, 0, 0, 0},
    '{8192, -8192, 40000, 0, 1, 1, 8192, -8192, 8192},
    '{0, 0, 0, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 1, 0, 0, 0},
    '{300, 300, 0, 1, 0, 0, 0, 0, 0},
    '{-1, -1, 0, 1, 1, 1, -1, -1, 0}
  };

  int unsigned coeff_sets [NUM_SETTINGS][2] = '{
    '{65535, 65535}, '{0, 0}, '{0, 65535}, '{65535, 0}, '{1638, 300}, '{0, 0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sfdtd_in_if #(.SampleWidth(SW)) pts_in ();
  sfdtd_out_if #(.SampleWidth(SW)) pts_out ();

  schrodinger_fdtd_sweep_1d_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req      (pts_in),
    .out_req     (pts_out)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [CFG_DATA_W-1:0] ra_q = LAPLACE_RST;
  logic [CFG_DATA_W-1:0] gain_q = GAIN_RST;
  longint left_re_q = 0;
  longint left_im_q = 0;
  logic signed [SW-1:0] held_re_q = '0;
  logic signed [SW-1:0] held_im_q = '0;
  logic [POT_W-1:0] held_pot_q = '0;
  logic [1:0] seen_q = SEEN_EMPTY;

  result_t due_results [$];
  result_t oldest;
  int errors = 0;
  int points_sent = 0;
  int results_checked = 0;
  int sweeps_closed = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_off_req = 1'b0;

  function automatic longint clamp_sample(input longint x);
    longint hi;
    hi = (longint'(1) << (SW - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint round_q14(input longint x);
    return (x + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic result_t make_result(input longint re, input longint im, input logic last);
    result_t r;
    longint mag;
    mag = (re * re + im * im) >> (SW - 2);
    r.re = re[SW-1:0];
    r.im = im[SW-1:0];
    r.prob = mag[SW+1:0];
    r.last = last;
    return r;
  endfunction

  // advance the sweep by one grid point and queue the results it releases
  function automatic void sweep_update(input point_t p);
    longint ra, phase, lap_i, lap_r, nr, ni;
    ra = longint'(ra_q);
    if (p.first) seen_q = SEEN_EMPTY;
    if (seen_q == SEEN_EMPTY) begin
      if (p.last) begin
        due_results.push_back(make_result(longint'(p.re), longint'(p.im), 1'b1));
      end else begin
        held_re_q = p.re;
        held_im_q = p.im;
        held_pot_q = p.pot;
        seen_q = SEEN_FIRST;
      end
      return;
    end
    if (seen_q == SEEN_FIRST) begin
      due_results.push_back(make_result(longint'(held_re_q), longint'(held_im_q), 1'b0));
      left_re_q = longint'(held_re_q);
      left_im_q = longint'(held_im_q);
    end else begin
      phase = (longint'(held_pot_q) * longint'(gain_q)) >> COEF_FRAC;
      lap_i = left_im_q - 2 * longint'(held_im_q) + longint'(p.im);
      nr = clamp_sample(longint'(held_re_q)
                        + round_q14(phase * longint'(held_im_q) - ra * lap_i));
      lap_r = left_re_q - 2 * nr + longint'(p.re);
      ni = clamp_sample(longint'(held_im_q) + round_q14(ra * lap_r - phase * nr));
      due_results.push_back(make_result(nr, ni, 1'b0));
      left_re_q = nr;
      left_im_q = ni;
    end
    if (p.last) begin
      due_results.push_back(make_result(longint'(p.re), longint'(p.im), 1'b1));
      seen_q = SEEN_EMPTY;
    end else begin
      held_re_q = p.re;
      held_im_q = p.im;
      held_pot_q = p.pot;
      seen_q = SEEN_INNER;
    end
  endfunction

  function automatic logic signed [SW-1:0] pick_corner();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic point_t random_point(input int unsigned style);
    point_t p;
    case (style)
      0: begin p.re = SW'($urandom); p.im = SW'($urandom); end
      1: begin
        p.re = SW'($urandom_range(0, 4095) - 2048);
        p.im = SW'($urandom_range(0, 4095) - 2048);
      end
      2: begin p.re = pick_corner(); p.im = pick_corner(); end
      default: begin
        p.re = SW'($urandom_range(0, 32767) - 16384);
        p.im = SW'($urandom_range(0, 32767) - 16384);
      end
    endcase
    p.pot = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : POT_W'($urandom);
    p.first = 1'b0;
    p.last = 1'b0;
    return p;
  endfunction

  // offer one grid point after an optional gap, predict once it is taken
  task automatic send_point(input point_t p);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      pts_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pts_in.valid <= 1'b1;
    pts_in.in_real <= p.re;
    pts_in.in_imag <= p.im;
    pts_in.in_potential <= p.pot;
    pts_in.first_point <= p.first;
    pts_in.last_point <= p.last;
    do @(posedge clk_i); while (!(pts_in.valid && pts_in.ready));
    sweep_update(p);
    points_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_LAPLACE) ra_q = val;
    else if (idx == CFG_GAIN) gain_q = val;
  endtask

  // drop valid, wait for every queued result, then let the sequencer go idle
  task automatic settle();
    pts_in.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly whole sweeps with random content; some with broken or missing marks
  task automatic random_traffic(input int budget);
    int len, k, kind;
    int unsigned style;
    point_t p;
    while (budget > 0) begin
      kind = $urandom_range(0, 15);
      style = $urandom_range(0, 3);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (k = 0; k < len; k++) begin
        p = random_point(style);
        p.first = (k == 0);
        p.last = (k == len - 1);
        if (kind == 0) begin
          p.first = ($urandom_range(0, 3) == 0);
          p.last = ($urandom_range(0, 3) == 0);
        end else if (kind == 1 && k == 0) begin
          p.first = 1'b0;
        end else if (kind == 2 && k == len - 1) begin
          p.last = 1'b0;
        end
        send_point(p);
        budget--;
      end
    end
  endtask

  task automatic report(input string field, input longint want, input longint got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // result side: random ready gaps, plus one long hold-off on request
  initial begin
    int gap;
    pts_out.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pts_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      gap = out_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        pts_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pts_out.ready <= 1'b1;
      do @(posedge clk_i); while (!(pts_out.valid && pts_out.ready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && pts_out.valid === 1'b1 && pts_out.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected, actual real %0d imag %0d",
                   $time, pts_out.out_real, pts_out.out_imag);
      end else begin
        oldest = due_results.pop_front();
        results_checked++;
        if (oldest.last) sweeps_closed++;
        if (pts_out.out_real !== oldest.re)
          report("real", longint'(oldest.re), longint'(pts_out.out_real));
        if (pts_out.out_imag !== oldest.im)
          report("imag", longint'(oldest.im), longint'(pts_out.out_imag));
        if (pts_out.out_probability !== oldest.prob)
          report("probability", longint'(oldest.prob), longint'(pts_out.out_probability));
        if (pts_out.out_last !== oldest.last)
          report("last", longint'(oldest.last), longint'(pts_out.out_last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    point_t p;
    result_t typed_res;
    int ph;
    logic [CFG_DATA_W-1:0] ra_val, gain_val;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    pts_in.valid = 1'b0;
    pts_in.in_real = '0;
    pts_in.in_imag = '0;
    pts_in.in_potential = '0;
    pts_in.first_point = 1'b0;
    pts_in.last_point = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sweeps under the reset coefficients
    foreach (directed_rows[i]) begin
      p.re = directed_rows[i].re;
      p.im = directed_rows[i].im;
      p.pot = directed_rows[i].pot;
      p.first = directed_rows[i].first;
      p.last = directed_rows[i].last;
      send_point(p);
      if (directed_rows[i].typed) begin
        typed_res.re = directed_rows[i].want_re;
        typed_res.im = directed_rows[i].want_im;
        typed_res.prob = directed_rows[i].want_prob;
        typed_res.last = 1'b1;
        void'(due_results.pop_back());
        due_results.push_back(typed_res);
      end
    end
    settle();

    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      ra_val = CFG_DATA_W'(coeff_sets[ph][0]);
      gain_val = CFG_DATA_W'(coeff_sets[ph][1]);
      if (ph == NUM_SETTINGS - 1) begin
        ra_val = CFG_DATA_W'($urandom);
        gain_val = CFG_DATA_W'($urandom);
      end
      write_reg(CFG_LAPLACE, ra_val);
      write_reg(CFG_GAIN, gain_val);
      if (ph == 1) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_we_i <= 1'b0;
      in_idle_on = (ph % 3 != 0);
      out_idle_on = (ph % 2 == 0);
      if (ph == 3) hold_off_req = 1'b1;
      random_traffic(POINTS_PER_SETTING);
      settle();
    end

    $display("Sent %0d grid points under %0d coefficient settings; checked %0d results.",
             points_sent, NUM_SETTINGS + 1, results_checked);
    $display("Closed %0d sweeps, including broken marks and one long result-side hold-off.",
             sweeps_closed);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
